@@ src/quaternion_vector_rotate_assert.svh @@
// Assertion macros for the quaternion vector rotator.
// Expects clk and rst in the including module's scope.
`ifndef QUATERNION_VECTOR_ROTATE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define QVR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/qvr_pkg.sv @@
// Shared types and constants for the quaternion vector rotator.
// No dependencies.
package qvr_pkg;

  localparam int unsigned DATA_W   = 16;             // rotor, vector and result width
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned PROD1_W  = 2 * DATA_W;     // rotor x vector
  localparam int unsigned P_W      = PROD1_W + 2;    // first Hamilton product terms
  localparam int unsigned PROD2_W  = P_W + DATA_W;   // p x rotor
  localparam int unsigned R_W      = PROD2_W + 2;    // second Hamilton product terms
  localparam int unsigned FRAC_W   = 28;             // Q2.14 squared
  localparam int unsigned Q_W      = R_W - FRAC_W;   // after scaling down

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTOR_REAL = 8'd0,
    REG_ROTOR_I    = 8'd1,
    REG_ROTOR_J    = 8'd2,
    REG_ROTOR_K    = 8'd3
  } cfg_reg_t;

  localparam logic signed [DATA_W-1:0] ROTOR_REAL_RESET = 16'sd16384;  // 1.0 in Q2.14

  typedef struct packed {
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
  } rotor_t;

  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } quat_p_t;

  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } vec_r_t;

endpackage

@@ src/quaternion_vector_rotate.sv @@
// Quaternion vector rotation, five register stages, one request per cycle
// while not in reset. A request's result appears on done once it has passed
// the products, p, the second products, r and the rounded output registers.
// Depth is set by the two multiply/sum pairs and the rounding stage.
// Reset clears the valid chain and loads the rotor with 1.0; busy is high only in reset.
`include "quaternion_vector_rotate_assert.svh"

module quaternion_vector_rotate (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qvr_pkg::DATA_W-1:0]   vec_x,
  input  logic signed [qvr_pkg::DATA_W-1:0]   vec_y,
  input  logic signed [qvr_pkg::DATA_W-1:0]   vec_z,
  input  logic                                cfg_we,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qvr_pkg::DATA_W-1:0]          cfg_data,
  output logic                                done,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_x,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_y,
  output logic signed [qvr_pkg::DATA_W-1:0]   out_z,
  output logic                                clipped
);

  qvr_pkg::rotor_t  rot;
  qvr_pkg::quat_p_t p;
  qvr_pkg::vec_r_t  r;
  logic             accept;
  logic             p_valid;
  logic             r_valid;

  assign busy   = rst;
  assign accept = start && !busy;

  // the user must change the rotor only while the pipeline is empty; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      rot.w <= qvr_pkg::ROTOR_REAL_RESET;
      rot.a <= '0;
      rot.b <= '0;
      rot.c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qvr_pkg::REG_ROTOR_REAL: rot.w <= cfg_data;
        qvr_pkg::REG_ROTOR_I:    rot.a <= cfg_data;
        qvr_pkg::REG_ROTOR_J:    rot.b <= cfg_data;
        qvr_pkg::REG_ROTOR_K:    rot.c <= cfg_data;
        default: ;
      endcase
    end
  end

  qvr_hamilton1 u_ham1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .rot       (rot),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .out_valid (p_valid),
    .p         (p)
  );

  qvr_hamilton2 u_ham2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .rot       (rot),
    .p         (p),
    .out_valid (r_valid),
    .r         (r)
  );

  qvr_round_sat u_rsat (
    .clk      (clk),
    .rst      (rst),
    .in_valid (r_valid),
    .r        (r),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .clipped  (clipped)
  );

  `QVR_ASSERT_IMPL(a_done_from_req, done, $past(accept, 5), "done without a request")
  `QVR_ASSERT_NEXT(a_mid_pipe, p_valid, ##1 r_valid ##1 done, "request lost mid pipeline")
  `QVR_ASSERT_IMPL(a_clip_at_rail, done && clipped,
    out_x == 16'sh7fff || out_x == 16'sh8000 || out_y == 16'sh7fff ||
    out_y == 16'sh8000 || out_z == 16'sh7fff || out_z == 16'sh8000,
    "clipped set with no component at a rail")

endmodule

@@ src/qvr_hamilton1.sv @@
// First Hamilton product q * (0, v): multiply stage then sum stage.
// Depends on qvr_pkg.
module qvr_hamilton1 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  qvr_pkg::rotor_t                    rot,
  input  logic signed [qvr_pkg::DATA_W-1:0]  vec_x,
  input  logic signed [qvr_pkg::DATA_W-1:0]  vec_y,
  input  logic signed [qvr_pkg::DATA_W-1:0]  vec_z,
  output logic                               out_valid,
  output qvr_pkg::quat_p_t                   p
);

  localparam int unsigned M_W = qvr_pkg::PROD1_W;
  localparam int unsigned S_W = qvr_pkg::P_W;

  logic                  v1;
  logic signed [M_W-1:0] wx, wy, wz, ax, ay, az, bx, by, bz, cx, cy, cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    wx <= M_W'(rot.w) * M_W'(vec_x);
    wy <= M_W'(rot.w) * M_W'(vec_y);
    wz <= M_W'(rot.w) * M_W'(vec_z);
    ax <= M_W'(rot.a) * M_W'(vec_x);
    ay <= M_W'(rot.a) * M_W'(vec_y);
    az <= M_W'(rot.a) * M_W'(vec_z);
    bx <= M_W'(rot.b) * M_W'(vec_x);
    by <= M_W'(rot.b) * M_W'(vec_y);
    bz <= M_W'(rot.b) * M_W'(vec_z);
    cx <= M_W'(rot.c) * M_W'(vec_x);
    cy <= M_W'(rot.c) * M_W'(vec_y);
    cz <= M_W'(rot.c) * M_W'(vec_z);
  end

  always_ff @(posedge clk) begin
    p.w <= -(S_W'(ax) + S_W'(by) + S_W'(cz));
    p.x <= S_W'(wx) + S_W'(bz) - S_W'(cy);
    p.y <= S_W'(wy) + S_W'(cx) - S_W'(az);
    p.z <= S_W'(wz) + S_W'(ay) - S_W'(bx);
  end

endmodule

@@ src/qvr_hamilton2.sv @@
// Second Hamilton product p * conj(q), vector part: multiply then sum.
// Depends on qvr_pkg.
module qvr_hamilton2 (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  qvr_pkg::rotor_t  rot,
  input  qvr_pkg::quat_p_t p,
  output logic             out_valid,
  output qvr_pkg::vec_r_t  r
);

  localparam int unsigned M_W = qvr_pkg::PROD2_W;
  localparam int unsigned S_W = qvr_pkg::R_W;

  logic                  v3;
  logic signed [M_W-1:0] pw_a, pw_b, pw_c, w_px, w_py, w_pz;
  logic signed [M_W-1:0] b_pz, c_py, c_px, a_pz, a_py, b_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3        <= in_valid;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    pw_a <= M_W'(p.w) * M_W'(rot.a);
    pw_b <= M_W'(p.w) * M_W'(rot.b);
    pw_c <= M_W'(p.w) * M_W'(rot.c);
    w_px <= M_W'(p.x) * M_W'(rot.w);
    w_py <= M_W'(p.y) * M_W'(rot.w);
    w_pz <= M_W'(p.z) * M_W'(rot.w);
    b_pz <= M_W'(p.z) * M_W'(rot.b);
    c_py <= M_W'(p.y) * M_W'(rot.c);
    c_px <= M_W'(p.x) * M_W'(rot.c);
    a_pz <= M_W'(p.z) * M_W'(rot.a);
    a_py <= M_W'(p.y) * M_W'(rot.a);
    b_px <= M_W'(p.x) * M_W'(rot.b);
  end

  always_ff @(posedge clk) begin
    r.x <= S_W'(w_px) - S_W'(pw_a) + S_W'(b_pz) - S_W'(c_py);
    r.y <= S_W'(w_py) - S_W'(pw_b) + S_W'(c_px) - S_W'(a_pz);
    r.z <= S_W'(w_pz) - S_W'(pw_c) + S_W'(a_py) - S_W'(b_px);
  end

endmodule

@@ src/qvr_round_sat.sv @@
// Scale by 2^-28 with round half up, saturate to 16 bits, flag clipping.
// Depends on qvr_pkg.
module qvr_round_sat (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  qvr_pkg::vec_r_t                   r,
  output logic                              done,
  output logic signed [qvr_pkg::DATA_W-1:0] out_x,
  output logic signed [qvr_pkg::DATA_W-1:0] out_y,
  output logic signed [qvr_pkg::DATA_W-1:0] out_z,
  output logic                              clipped
);

  localparam int unsigned R_W    = qvr_pkg::R_W;
  localparam int unsigned Q_W    = qvr_pkg::Q_W;
  localparam int unsigned FRAC_W = qvr_pkg::FRAC_W;
  localparam int unsigned D_W    = qvr_pkg::DATA_W;

  localparam logic signed [R_W-1:0] HALF   = R_W'(1) << (FRAC_W - 1);
  localparam logic signed [Q_W-1:0] Q_MAX  = Q_W'((1 << (D_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN  = -Q_W'(1 << (D_W - 1));

  logic signed [R_W-1:0] tx, ty, tz;
  logic signed [Q_W-1:0] qx, qy, qz;
  logic                  hx, lx, hy, ly, hz, lz;
  logic signed [D_W-1:0] sx, sy, sz;

  // adding half then taking the top bits floors toward -inf
  always_comb begin
    tx = r.x + HALF;
    ty = r.y + HALF;
    tz = r.z + HALF;
    qx = tx[R_W-1:FRAC_W];
    qy = ty[R_W-1:FRAC_W];
    qz = tz[R_W-1:FRAC_W];
    hx = qx > Q_MAX;
    lx = qx < Q_MIN;
    hy = qy > Q_MAX;
    ly = qy < Q_MIN;
    hz = qz > Q_MAX;
    lz = qz < Q_MIN;
    sx = hx ? Q_MAX[D_W-1:0] : (lx ? Q_MIN[D_W-1:0] : qx[D_W-1:0]);
    sy = hy ? Q_MAX[D_W-1:0] : (ly ? Q_MIN[D_W-1:0] : qy[D_W-1:0]);
    sz = hz ? Q_MAX[D_W-1:0] : (lz ? Q_MIN[D_W-1:0] : qz[D_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x   <= sx;
    out_y   <= sy;
    out_z   <= sz;
    clipped <= hx | lx | hy | ly | hz | lz;
  end

endmodule
